/* rtl/uac_pkg.sv */
package uac_pkg;

  localparam int ADDR_W      = 48;
  localparam int LEN_W       = 16;
  localparam int COUNT_OUT_W = 8;

  localparam logic [LEN_W-1:0] COUNTED_LENGTH = 16'd60;

  localparam logic CMD_OBSERVE = 1'b0;
  localparam logic CMD_CLEAR   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic              command;
    logic [LEN_W-1:0]  frame_length;
    logic [ADDR_W-1:0] station_address;
  } req_t;

  typedef struct packed {
    logic [COUNT_OUT_W-1:0] known_count;
    logic                   added;
    logic                   wrapped;
  } result_t;

endpackage

/* rtl/uac_table.sv */
module uac_table #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [uac_pkg::ADDR_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [uac_pkg::ADDR_W-1:0] rd_data
);

  logic [uac_pkg::ADDR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/uac_seq.sv */
module uac_seq #(
  parameter int TABLE_DEPTH = 256,
  parameter int FULL_LIMIT  = 200
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  uac_pkg::req_t     req,
  output logic              res_valid,
  input  logic              res_ready,
  output uac_pkg::result_t  res
);

  localparam int AW         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
  localparam int FULL_LEVEL = (FULL_LIMIT < TABLE_DEPTH) ? FULL_LIMIT : TABLE_DEPTH;

  uac_pkg::seq_state_t state, state_next;

  logic [CNT_W-1:0]           count, count_next;
  logic [CNT_W-1:0]           rd_idx, rd_idx_next;
  logic                       pend, pend_next;
  logic [uac_pkg::ADDR_W-1:0] addr, addr_next;
  logic [CNT_W-1:0]           res_count, res_count_next;
  logic                       res_added, res_added_next;
  logic                       res_wrapped, res_wrapped_next;

  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic                       rd_en;
  logic [uac_pkg::ADDR_W-1:0] rd_data;
  logic                       accept;
  logic                       match;
  logic                       search_miss;
  logic [CNT_W+7:0]           count_wide;

  uac_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (addr_next),
    .rd_en   (rd_en),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  assign accept      = req_valid && (state == uac_pkg::ST_IDLE);
  assign match       = pend && (rd_data == addr);
  assign search_miss = !rd_en && !match;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      uac_pkg::ST_IDLE: begin
        if (accept) begin
          if (req.command == uac_pkg::CMD_OBSERVE &&
              req.frame_length == uac_pkg::COUNTED_LENGTH &&
              count != '0 && count < CNT_W'(FULL_LEVEL)) begin
            state_next = uac_pkg::ST_SEARCH;
          end else begin
            state_next = uac_pkg::ST_DONE;
          end
        end
      end
      uac_pkg::ST_SEARCH: begin
        if (match || search_miss) begin
          state_next = uac_pkg::ST_DONE;
        end
      end
      uac_pkg::ST_DONE: begin
        if (res_ready) begin
          state_next = uac_pkg::ST_IDLE;
        end
      end
      default: state_next = uac_pkg::ST_IDLE;
    endcase
  end

  // Memory control and data path.
  always_comb begin
    count_next       = count;
    rd_idx_next      = rd_idx;
    pend_next        = 1'b0;
    addr_next        = addr;
    res_count_next   = res_count;
    res_added_next   = res_added;
    res_wrapped_next = res_wrapped;
    wr_en            = 1'b0;
    wr_addr          = count[AW-1:0];
    rd_en            = 1'b0;
    unique case (state)
      uac_pkg::ST_IDLE: begin
        if (accept) begin
          addr_next        = req.station_address;
          rd_idx_next      = '0;
          res_added_next   = 1'b0;
          res_wrapped_next = 1'b0;
          res_count_next   = count;
          if (req.command == uac_pkg::CMD_CLEAR) begin
            count_next     = '0;
            res_count_next = '0;
          end else if (req.frame_length == uac_pkg::COUNTED_LENGTH) begin
            // A full or empty table starts over with this address, without a search.
            if (count >= CNT_W'(FULL_LEVEL) || count == '0) begin
              wr_en            = 1'b1;
              wr_addr          = '0;
              count_next       = CNT_W'(1);
              res_count_next   = CNT_W'(1);
              res_added_next   = 1'b1;
              res_wrapped_next = (count != '0);
            end
          end
        end
      end
      uac_pkg::ST_SEARCH: begin
        rd_en = (rd_idx < count) && !match;
        if (rd_en) begin
          rd_idx_next = rd_idx + CNT_W'(1);
          pend_next   = 1'b1;
        end
        if (!match && search_miss) begin
          wr_en          = 1'b1;
          count_next     = count + CNT_W'(1);
          res_count_next = count + CNT_W'(1);
          res_added_next = 1'b1;
        end
      end
      uac_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= uac_pkg::ST_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx      <= rd_idx_next;
    addr        <= addr_next;
    res_count   <= res_count_next;
    res_added   <= res_added_next;
    res_wrapped <= res_wrapped_next;
  end

  assign count_wide      = {8'd0, res_count};
  assign req_ready       = (state == uac_pkg::ST_IDLE);
  assign res_valid       = (state == uac_pkg::ST_DONE);
  assign res.known_count = count_wide[uac_pkg::COUNT_OUT_W-1:0];
  assign res.added       = res_added;
  assign res.wrapped     = res_wrapped;

endmodule

/* rtl/unique_address_counter_core.sv */
// Counts distinct 48-bit station addresses. Each input item either clears the
// table (tuser high) or observes a frame; only frames of length 60 are counted,
// and the address is looked up by a linear scan of a one-port-read table
// memory, one entry per cycle, then appended if absent. When the table holds
// min(FULL_LIMIT, TABLE_DEPTH) entries, the next counted address restarts it
// as the only entry. Every item gives exactly one result item. Clears,
// uncounted lengths, the empty table and the full-table restart need no scan;
// a new item is taken only once the last one's result has been passed on.
// The result sits in an output register, so the next item is accepted while a
// result waits downstream. No clearing pass is needed after reset.
module unique_address_counter_core #(
  parameter int TABLE_DEPTH = 256,
  parameter int FULL_LIMIT  = 200
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // frame_length[15:0], station_address[63:16]
  input  logic        s_axis_tuser,   // command[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // known_count[7:0], added[8], wrapped[9], zero
);

  uac_pkg::req_t    req;
  uac_pkg::result_t res;
  uac_pkg::result_t out_res;
  logic             res_valid;
  logic             res_ready;

  assign req.command         = s_axis_tuser;
  assign req.frame_length    = s_axis_tdata[15:0];
  assign req.station_address = s_axis_tdata[63:16];

  uac_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .FULL_LIMIT  (FULL_LIMIT)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_axis_tvalid),
    .req_ready (s_axis_tready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {6'd0, out_res.wrapped, out_res.added, out_res.known_count};

endmodule
